// ===== hw/rtl/cse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants of the chained sprite entry expander.
// ----------------------------------------------------------------------------
package cse_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_X_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_FLIPPED  = 2'd1;

	// position decode constants
	localparam logic [8:0]  X_WRAP_LIMIT = 9'd496;
	localparam logic [8:0]  Y_ORIGIN     = 9'd256;
	localparam logic [9:0]  FLIP_X_BASE  = 10'd304;
	localparam logic [10:0] FLIP_Y_BASE  = 11'd240;
	localparam logic [10:0] TILE_STEP    = 11'd16;

	// controller to datapath
	typedef struct packed {
		logic cap;   // latch the entry at the input port
		logic load;  // move the latched entry to the output tile register
		logic step;  // advance the output tile register to the next chained tile
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_enable; // enable bit of the entry at the input port
		logic last;      // output tile register holds the final tile of its chain
	} sts_t;

endpackage : cse_pkg
`default_nettype wire

// ===== hw/rtl/cse_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_if
// Handshake channels of the expander: configuration, entry in, tile out.
// ----------------------------------------------------------------------------
interface cse_cfg_if;
	import cse_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface : cse_cfg_if

interface cse_entry_if;
	logic        valid;
	logic        ready;
	logic [15:0] y_word;
	logic [15:0] attr_word;
	logic [15:0] number_low_word;
	logic [15:0] number_high_word;
	logic [15:0] colour_word;
	logic [15:0] x_word;

	modport source (output valid, y_word, attr_word, number_low_word, number_high_word,
		colour_word, x_word, input ready);
	modport sink (input valid, y_word, attr_word, number_low_word, number_high_word,
		colour_word, x_word, output ready);
endinterface : cse_entry_if

interface cse_tile_if;
	logic               valid;
	logic               ready;
	logic        [15:0] tile_number;
	logic        [3:0]  colour_bank;
	logic               mirror_x;
	logic               mirror_y;
	logic signed [9:0]  screen_x;
	logic signed [10:0] screen_y;
	logic               last_tile;

	modport source (output valid, tile_number, colour_bank, mirror_x, mirror_y, screen_x,
		screen_y, last_tile, input ready);
	modport sink (input valid, tile_number, colour_bank, mirror_x, mirror_y, screen_x,
		screen_y, last_tile, output ready);
endinterface : cse_tile_if
`default_nettype wire

// ===== hw/rtl/chained_sprite_entry_expander_top.sv =====
`default_nettype none
// An accepted entry is held in the holding register, then its first tile is loaded
// into the output tile register. Throughput: an enabled entry emits one tile per cycle
// while tile.ready is high, over its chain length of 1 to 8; the holding register frees
// only as it loads. A disabled entry is accepted and produces nothing.
// The next entry is taken into a holding register while the current chain is emitted.
// Reset: arst_n asynchronous, clears control state and the configuration registers.
// ----------------------------------------------------------------------------
// chained_sprite_entry_expander_top
// Expands one sprite list entry into its chain of tile commands.
// ----------------------------------------------------------------------------
module chained_sprite_entry_expander_top (
	input  logic        clk,
	input  logic        arst_n,
	cse_cfg_if.sink     cfg,
	cse_entry_if.sink   entry,
	cse_tile_if.source  tile
);
	import cse_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	cse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (entry.valid),
		.in_ready  (entry.ready),
		.out_valid (tile.valid),
		.out_ready (tile.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cse_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.y_word           (entry.y_word),
		.attr_word        (entry.attr_word),
		.number_low_word  (entry.number_low_word),
		.number_high_word (entry.number_high_word),
		.colour_word      (entry.colour_word),
		.x_word           (entry.x_word),
		.tile_number      (tile.tile_number),
		.colour_bank      (tile.colour_bank),
		.mirror_x         (tile.mirror_x),
		.mirror_y         (tile.mirror_y),
		.screen_x         (tile.screen_x),
		.screen_y         (tile.screen_y),
		.last_tile        (tile.last_tile)
	);

endmodule : chained_sprite_entry_expander_top
`default_nettype wire

// ===== hw/rtl/cse_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_datapath
// Config registers, entry decode, entry holding register and tile generator.
// ----------------------------------------------------------------------------
module cse_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cse_pkg::cmd_t                  cmd,
	output cse_pkg::sts_t                  sts,
	input  logic                           cfg_we,
	input  logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cse_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [15:0]                    y_word,
	input  logic [15:0]                    attr_word,
	input  logic [15:0]                    number_low_word,
	input  logic [15:0]                    number_high_word,
	input  logic [15:0]                    colour_word,
	input  logic [15:0]                    x_word,
	output logic [15:0]                    tile_number,
	output logic [3:0]                     colour_bank,
	output logic                           mirror_x,
	output logic                           mirror_y,
	output logic signed [9:0]              screen_x,
	output logic signed [10:0]             screen_y,
	output logic                           last_tile
);
	import cse_pkg::*;

	logic [3:0]  off_q;
	logic        flip_q;

	logic [8:0]  x9;
	logic [9:0]  x_dec;
	logic [9:0]  x_off;
	logic [9:0]  x_pos;
	logic [8:0]  y9;
	logic [8:0]  y_raw;
	logic [10:0] y_dec;
	logic [10:0] y_pos;
	logic [10:0] y_start;
	logic [10:0] span;
	logic        mx;
	logic        my;

	logic [15:0] ent_tile_q;
	logic [3:0]  ent_bank_q;
	logic        ent_mx_q;
	logic        ent_my_q;
	logic [9:0]  ent_x_q;
	logic [10:0] ent_y_q;
	logic [2:0]  ent_cnt_q;

	logic [15:0] tile_q;
	logic [3:0]  bank_q;
	logic        mx_q;
	logic        my_q;
	logic [9:0]  x_q;
	logic [10:0] y_q;
	logic [2:0]  rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			flip_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPRITE_X_OFFSET: off_q  <= cfg_data;
				REG_SCREEN_FLIPPED:  flip_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		x9    = {attr_word[2], x_word[7:0]};
		// values past the right edge wrap to the left of the screen
		x_dec = (x9 > X_WRAP_LIMIT) ? {1'b1, x9} : {1'b0, x9};
		x_off = x_dec + {6'd0, off_q};
		y9    = {attr_word[1], y_word[7:0]};
		y_raw = Y_ORIGIN - y9;
		y_dec = {2'b00, y_raw} - TILE_STEP;
		span  = {4'd0, attr_word[7:5], 4'd0};
		mx    = attr_word[4] ^ flip_q;
		my    = attr_word[3] ^ flip_q;
		if (flip_q) begin
			x_pos = FLIP_X_BASE - x_off;
			// the horizontal offset also lands on y here
			y_pos = FLIP_Y_BASE - y_dec - {7'd0, off_q};
		end else begin
			x_pos = x_off;
			y_pos = y_dec;
		end
		// first tile of the chain; later tiles move 16 down when my is set, else up
		if (!flip_q && my) begin
			y_start = y_pos - span;
		end else if (flip_q && !my) begin
			y_start = y_pos + span;
		end else begin
			y_start = y_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			ent_tile_q <= {number_high_word[7:0], number_low_word[7:0]};
			ent_bank_q <= colour_word[3:0];
			ent_mx_q   <= mx;
			ent_my_q   <= my;
			ent_x_q    <= x_pos;
			ent_y_q    <= y_start;
			ent_cnt_q  <= attr_word[7:5];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tile_q <= ent_tile_q;
			bank_q <= ent_bank_q;
			mx_q   <= ent_mx_q;
			my_q   <= ent_my_q;
			x_q    <= ent_x_q;
			y_q    <= ent_y_q;
			rem_q  <= ent_cnt_q;
		end else if (cmd.step) begin
			tile_q <= tile_q + 16'd1;
			y_q    <= my_q ? (y_q + TILE_STEP) : (y_q - TILE_STEP);
			rem_q  <= rem_q - 3'd1;
		end
	end

	assign sts.in_enable = attr_word[0];
	assign sts.last      = (rem_q == 3'd0);

	assign tile_number = tile_q;
	assign colour_bank = bank_q;
	assign mirror_x    = mx_q;
	assign mirror_y    = my_q;
	assign screen_x    = x_q;
	assign screen_y    = y_q;
	assign last_tile   = (rem_q == 3'd0);

endmodule : cse_datapath
`default_nettype wire

// ===== hw/rtl/cse_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_ctrl
// Controller: entry holding flag and tile emission state machine.
// ----------------------------------------------------------------------------
module cse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  cse_pkg::sts_t sts,
	output cse_pkg::cmd_t cmd
);
	import cse_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;
	logic ent_full_q;
	logic ent_full_d;
	logic out_fire;
	logic out_free;

	always_comb begin
		out_fire = (state_q == ST_EMIT) && out_ready;
		// output register can take a new entry when empty or on its last beat
		out_free = (state_q == ST_IDLE) || (out_fire && sts.last);
		in_ready = !ent_full_q;
		cmd.cap  = in_valid && !ent_full_q;
		cmd.load = ent_full_q && out_free;
		cmd.step = out_fire && !sts.last;

		ent_full_d = ent_full_q;
		if (cmd.load) begin
			ent_full_d = 1'b0;
		end else if (cmd.cap && sts.in_enable) begin
			ent_full_d = 1'b1;
		end

		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_fire && sts.last && !cmd.load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ent_full_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ent_full_q <= ent_full_d;
		end
	end

	assign out_valid = (state_q == ST_EMIT);

endmodule : cse_ctrl
`default_nettype wire

// ===== hw/rtl/cse_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_checker
// Port level checks of the tile output channel, bound to the top level.
// ----------------------------------------------------------------------------
module cse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               tile_valid,
	input logic               tile_ready,
	input logic        [15:0] tile_number,
	input logic        [3:0]  colour_bank,
	input logic signed [9:0]  screen_x,
	input logic               last_tile
);

	// nothing to show right after reset
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !tile_valid)
		else $error("tile valid right after reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && !tile_ready |=> tile_valid && $stable(tile_number))
		else $error("stalled tile changed");

	// chained tiles follow back to back with consecutive numbers
	a_chain_number: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && tile_ready && !last_tile |=>
			tile_valid && (tile_number == $past(tile_number) + 16'd1))
		else $error("chain tile number not consecutive");

	a_chain_column: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && tile_ready && !last_tile |=>
			$stable(screen_x) && $stable(colour_bank))
		else $error("chain tile moved column or bank");

endmodule : cse_checker

bind chained_sprite_entry_expander_top cse_checker u_cse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tile_valid  (tile.valid),
	.tile_ready  (tile.ready),
	.tile_number (tile.tile_number),
	.colour_bank (tile.colour_bank),
	.screen_x    (tile.screen_x),
	.last_tile   (tile.last_tile)
);
`default_nettype wire
